[src/gdsd_pkg.sv]
// ----------------------------------------------------------------------------
// gdsd_pkg - shared types, constants and date functions
// Calendar helpers for the Gregorian date step and difference pipeline.
// ----------------------------------------------------------------------------
package gdsd_pkg;

  localparam int YEAR_LIMIT = 9999;
  localparam logic [15:0] YEAR_MAX = 16'(YEAR_LIMIT);

  localparam int YW  = 14;   // year field width
  localparam int AYW = 15;   // anniversary year, may run a few years past the limit
  localparam int SW  = 23;   // day serial width
  localparam int CW  = 22;   // day count width

  localparam logic [CW-1:0] COUNT_MAX = '1;
  localparam logic [3:0]    MONTHS    = 4'd12;
  localparam logic [3:0]    FEBRUARY  = 4'd2;
  localparam logic [4:0]    LEAP_DAY  = 5'd29;

  // Multiplicative inverse of 25 modulo 2^16 and the divisibility bound
  localparam logic [15:0] DIV25_INV = 16'h5C29;
  localparam logic [15:0] DIV25_LIM = 16'd2621;
  // Reciprocal of 100 scaled by 2^21; exact for operands below 43690
  localparam logic [31:0] DIV100_MUL = 32'd20972;

  typedef enum logic [1:0] {
    OP_NEXT  = 2'd0,
    OP_PREV  = 2'd1,
    OP_DIFF  = 2'd2,
    OP_ANNIV = 2'd3
  } op_t;

  typedef struct packed {
    op_t             op;
    logic [4:0]      day;
    logic [3:0]      month;
    logic [YW-1:0]   year;
    logic            leap;
    logic [4:0]      len;
  } step_in_t;

  typedef struct packed {
    logic [4:0]      day;
    logic [3:0]      month;
    logic [YW-1:0]   year;
    logic            status;
  } step_out_t;

  function automatic logic is_div25(logic [15:0] y);
    logic [15:0] p;
    p = y * DIV25_INV;
    return p <= DIV25_LIM;
  endfunction

  // Divisible by 4, and by 16 whenever divisible by 25
  function automatic logic is_leap(logic [15:0] y);
    return (y[1:0] == 2'd0) && (!is_div25(y) || (y[3:0] == 4'd0));
  endfunction

  function automatic logic [7:0] div100(logic [15:0] x);
    logic [31:0] p;
    p = 32'(x) * DIV100_MUL;
    return p[28:21];
  endfunction

  function automatic logic [4:0] days_in(logic [3:0] m, logic leap);
    case (m)
      4'd2:                   return leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
      default:                return 5'd31;
    endcase
  endfunction

  function automatic logic [8:0] month_start(logic [3:0] m);
    case (m)
      4'd2:    return 9'd31;
      4'd3:    return 9'd59;
      4'd4:    return 9'd90;
      4'd5:    return 9'd120;
      4'd6:    return 9'd151;
      4'd7:    return 9'd181;
      4'd8:    return 9'd212;
      4'd9:    return 9'd243;
      4'd10:   return 9'd273;
      4'd11:   return 9'd304;
      4'd12:   return 9'd334;
      default: return 9'd0;
    endcase
  endfunction

  function automatic logic [3:0] clamp_month(logic [3:0] m);
    if (m == 4'd0) return 4'd1;
    if (m > MONTHS) return MONTHS;
    return m;
  endfunction

  function automatic logic [4:0] clamp_day(logic [4:0] d, logic [4:0] len);
    if (d == 5'd0) return 5'd1;
    if (d > len) return len;
    return d;
  endfunction

  // Days from 1 January of year 0; q1 = (y+99)/100, q2 = (y+399)/100
  function automatic logic [SW-1:0] serial_days(logic [4:0] d, logic [3:0] m,
                                                logic [AYW-1:0] y, logic leap,
                                                logic [7:0] q1, logic [7:0] q2);
    logic [15:0]   y4;
    logic [SW-1:0] s;
    y4 = (16'(y) + 16'd3) >> 2;
    s  = SW'(y) * SW'(365) + SW'(y4) - SW'(q1) + SW'(q2[7:2])
       + SW'(month_start(m)) + SW'(d) - SW'(1)
       + SW'((m > FEBRUARY) && leap);
    return s;
  endfunction

endpackage

[src/gdsd_step.sv]
// ----------------------------------------------------------------------------
// gdsd_step - next and previous day of a clamped date
// Saturates at the ends of the year range and flags it in status.
// ----------------------------------------------------------------------------
module gdsd_step (
  input  gdsd_pkg::step_in_t  step_in,
  output gdsd_pkg::step_out_t step_out
);
  import gdsd_pkg::*;

  always_comb begin
    step_out.day    = 5'd1;
    step_out.month  = 4'd1;
    step_out.year   = '0;
    step_out.status = 1'b0;
    case (step_in.op)
      OP_NEXT: begin
        step_out.day   = step_in.day;
        step_out.month = step_in.month;
        step_out.year  = step_in.year;
        if (step_in.day < step_in.len) begin
          step_out.day = step_in.day + 5'd1;
        end else if (step_in.month < MONTHS) begin
          step_out.day   = 5'd1;
          step_out.month = step_in.month + 4'd1;
        end else if (16'(step_in.year) < YEAR_MAX) begin
          step_out.day   = 5'd1;
          step_out.month = 4'd1;
          step_out.year  = step_in.year + YW'(1);
        end else begin
          step_out.status = 1'b1;
        end
      end
      OP_PREV: begin
        step_out.day   = step_in.day;
        step_out.month = step_in.month;
        step_out.year  = step_in.year;
        if (step_in.day > 5'd1) begin
          step_out.day = step_in.day - 5'd1;
        end else if (step_in.month > 4'd1) begin
          step_out.month = step_in.month - 4'd1;
          step_out.day   = days_in(step_in.month - 4'd1, step_in.leap);
        end else if (step_in.year != '0) begin
          step_out.year  = step_in.year - YW'(1);
          step_out.month = MONTHS;
          step_out.day   = 5'd31;
        end else begin
          step_out.status = 1'b1;
        end
      end
      default: begin
        // hold the neutral date for counting operations
      end
    endcase
  end

endmodule

[src/gregorian_date_step_and_difference_top.sv]
// ----------------------------------------------------------------------------
// gregorian_date_step_and_difference_top - Gregorian date arithmetic pipeline
// Next day, previous day, days between and days until anniversary.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall) carries op and two dates A and B.
//   Response channel (rsp_valid / rsp_stall) returns one transaction per
//   request: a stepped date (day_out, month_out, year_out) or a day_count,
//   with status set when a step leaves the year range or a count saturates.
//   A transaction moves at a clock edge with valid high and stall low.
// Latency and throughput:
//   Six register stages, s1 to s6; an accepted request enters s1 and moves
//   through s2 to s5 to show on rsp_valid from s6. One transaction per cycle
//   is sustained while rsp_stall is low: no stage iterates.
// Reset:
//   rst (synchronous, active high) clears every stage valid bit; no request
//   in flight survives. Payload registers are not reset.
// Stall:
//   Each stage loads when it is empty or its successor moves, so bubbles
//   close up behind a stalled output. req_stall rises only when all six
//   stages hold work and the receiver stalls; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module gregorian_date_step_and_difference_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  logic [1:0]           op,
  input  logic [4:0]           day_a,
  input  logic [3:0]           month_a,
  input  logic [gdsd_pkg::YW-1:0] year_a,
  input  logic [4:0]           day_b,
  input  logic [3:0]           month_b,
  input  logic [gdsd_pkg::YW-1:0] year_b,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output logic [4:0]           day_out,
  output logic [3:0]           month_out,
  output logic [gdsd_pkg::YW-1:0] year_out,
  output logic [gdsd_pkg::CW-1:0] day_count,
  output logic                 status
);
  import gdsd_pkg::*;

  localparam int NSTAGE = 6;

  // Stage 1: clamped months and years, leap flags
  typedef struct packed {
    op_t           op;
    logic [4:0]    da_raw;
    logic [4:0]    db_raw;
    logic [3:0]    ma;
    logic [3:0]    mb;
    logic [YW-1:0] ya;
    logic [YW-1:0] yb;
    logic          leap_a;
    logic          leap_b;
  } s1_t;

  // Stage 2: clamped days, step result, target year before leap search
  typedef struct packed {
    op_t            op;
    logic [4:0]     da;
    logic [4:0]     db;
    logic [3:0]     ma;
    logic [3:0]     mb;
    logic [YW-1:0]  ya;
    logic [AYW-1:0] ysel;
    logic           leap_a;
    logic           nl_en;
    step_out_t      step;
  } s2_t;

  // Stage 3: final target year, century quotients of year A
  typedef struct packed {
    op_t            op;
    logic [4:0]     da;
    logic [4:0]     db;
    logic [3:0]     ma;
    logic [3:0]     mb;
    logic [YW-1:0]  ya;
    logic [AYW-1:0] yfin;
    logic           leap_a;
    logic [7:0]     q1a;
    logic [7:0]     q2a;
    step_out_t      step;
  } s3_t;

  // Stage 4: serial of A, century quotients and leap flag of B
  typedef struct packed {
    op_t            op;
    logic [SW-1:0]  sa;
    logic [4:0]     db;
    logic [3:0]     mb;
    logic [AYW-1:0] yfin;
    logic           leap_bf;
    logic [7:0]     q1b;
    logic [7:0]     q2b;
    step_out_t      step;
  } s4_t;

  // Stage 5: both serials
  typedef struct packed {
    op_t           op;
    logic [SW-1:0] sa;
    logic [SW-1:0] sb;
    step_out_t     step;
  } s5_t;

  // Stage 6: output register
  typedef struct packed {
    logic [4:0]    day;
    logic [3:0]    month;
    logic [YW-1:0] year;
    logic [CW-1:0] count;
    logic          status;
  } s6_t;

  logic [NSTAGE-1:0] vld;
  logic [NSTAGE-1:0] rdy;

  s1_t s1, s1_next;
  s2_t s2, s2_next;
  s3_t s3, s3_next;
  s4_t s4, s4_next;
  s5_t s5, s5_next;
  s6_t s6, s6_next;

  step_in_t  step_in;
  step_out_t step_res;

  // Pipeline flow: a stage loads when empty or when its content moves on
  always_comb begin
    rdy[NSTAGE-1] = !vld[NSTAGE-1] || !rsp_stall;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign req_stall = !rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= req_valid;
      for (int k = 1; k < NSTAGE; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // Stage 1: clamp months and years, take leap flags of both years
  always_comb begin
    s1_next.op     = op_t'(op);
    s1_next.da_raw = day_a;
    s1_next.db_raw = day_b;
    s1_next.ma     = clamp_month(month_a);
    s1_next.mb     = clamp_month(month_b);
    s1_next.ya     = (16'(year_a) > YEAR_MAX) ? YW'(YEAR_LIMIT) : year_a;
    s1_next.yb     = (16'(year_b) > YEAR_MAX) ? YW'(YEAR_LIMIT) : year_b;
    s1_next.leap_a = is_leap(16'(s1_next.ya));
    s1_next.leap_b = is_leap(16'(s1_next.yb));
  end

  // Stage 2: clamp days, step the date, pick the anniversary year
  logic [4:0] len_a;
  logic [4:0] len_b;
  logic       after_a;

  always_comb begin
    len_a = days_in(s1.ma, s1.leap_a);
    // date B counts February as 29 days when looking for an anniversary
    len_b = (s1.op == OP_DIFF) ? days_in(s1.mb, s1.leap_b) : days_in(s1.mb, 1'b1);

    s2_next.op     = s1.op;
    s2_next.da     = clamp_day(s1.da_raw, len_a);
    s2_next.db     = clamp_day(s1.db_raw, len_b);
    s2_next.ma     = s1.ma;
    s2_next.mb     = s1.mb;
    s2_next.ya     = s1.ya;
    s2_next.leap_a = s1.leap_a;

    // anniversary already passed this year: advance to the next one
    after_a = (s1.mb < s1.ma) || ((s1.mb == s1.ma) && (s2_next.db < s2_next.da));
    s2_next.ysel  = (s1.op == OP_DIFF) ? AYW'(s1.yb) : AYW'(s1.ya) + AYW'(after_a);
    s2_next.nl_en = (s1.op == OP_ANNIV) && (s1.mb == FEBRUARY) && (s2_next.db == LEAP_DAY);

    step_in.op    = s1.op;
    step_in.day   = s2_next.da;
    step_in.month = s1.ma;
    step_in.year  = s1.ya;
    step_in.leap  = s1.leap_a;
    step_in.len   = len_a;
    s2_next.step  = step_res;
  end

  gdsd_step u_step (
    .step_in  (step_in),
    .step_out (step_res)
  );

  // Stage 3: leap day anniversary moves to the next leap year on or after it; quotients of year A
  logic [AYW-1:0] ysum;
  logic [AYW-1:0] yup4;
  logic           cent_nl;

  always_comb begin
    // round up to a multiple of four; skip a century that is not a leap year
    ysum    = s2.ysel + AYW'(3);
    yup4    = {ysum[AYW-1:2], 2'b00};
    cent_nl = is_div25(16'(yup4)) && (yup4[3:0] != 4'd0);

    s3_next.op     = s2.op;
    s3_next.da     = s2.da;
    s3_next.db     = s2.db;
    s3_next.ma     = s2.ma;
    s3_next.mb     = s2.mb;
    s3_next.ya     = s2.ya;
    s3_next.leap_a = s2.leap_a;
    s3_next.yfin   = s2.nl_en ? (cent_nl ? yup4 + AYW'(4) : yup4) : s2.ysel;
    s3_next.q1a    = div100(16'(s2.ya) + 16'd99);
    s3_next.q2a    = div100(16'(s2.ya) + 16'd399);
    s3_next.step   = s2.step;
  end

  // Stage 4: serial of date A; quotients and leap flag of the target year
  always_comb begin
    s4_next.op      = s3.op;
    s4_next.sa      = serial_days(s3.da, s3.ma, AYW'(s3.ya), s3.leap_a, s3.q1a, s3.q2a);
    s4_next.db      = s3.db;
    s4_next.mb      = s3.mb;
    s4_next.yfin    = s3.yfin;
    s4_next.leap_bf = is_leap(16'(s3.yfin));
    s4_next.q1b     = div100(16'(s3.yfin) + 16'd99);
    s4_next.q2b     = div100(16'(s3.yfin) + 16'd399);
    s4_next.step    = s3.step;
  end

  // Stage 5: serial of the target date
  always_comb begin
    s5_next.op   = s4.op;
    s5_next.sa   = s4.sa;
    s5_next.sb   = serial_days(s4.db, s4.mb, s4.yfin, s4.leap_bf, s4.q1b, s4.q2b);
    s5_next.step = s4.step;
  end

  // Stage 6: difference, saturation and result selection
  logic [SW-1:0] diff_ab;
  logic [SW-1:0] diff_ba;
  logic [SW-1:0] cnt;
  logic          cnt_sat;

  always_comb begin
    diff_ab = s5.sa - s5.sb;
    diff_ba = s5.sb - s5.sa;
    case (s5.op)
      OP_DIFF:  cnt = (s5.sa > s5.sb) ? diff_ab : diff_ba;
      OP_ANNIV: cnt = diff_ba;
      default:  cnt = '0;
    endcase
    cnt_sat = cnt > SW'(COUNT_MAX);

    s6_next.day    = s5.step.day;
    s6_next.month  = s5.step.month;
    s6_next.year   = s5.step.year;
    s6_next.count  = cnt_sat ? COUNT_MAX : cnt[CW-1:0];
    s6_next.status = s5.step.status || cnt_sat;
  end

  // Payload registers advance with their stage valid bits
  always_ff @(posedge clk) begin
    if (rdy[0]) s1 <= s1_next;
    if (rdy[1]) s2 <= s2_next;
    if (rdy[2]) s3 <= s3_next;
    if (rdy[3]) s4 <= s4_next;
    if (rdy[4]) s5 <= s5_next;
    if (rdy[5]) s6 <= s6_next;
  end

  assign rsp_valid = vld[NSTAGE-1];
  assign day_out   = s6.day;
  assign month_out = s6.month;
  assign year_out  = s6.year;
  assign day_count = s6.count;
  assign status    = s6.status;

endmodule
